[rtl/clex_pkg.sv]
// Shared types, constants and character-class functions for the C subset lexer.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package clex_pkg;

    localparam int KIND_W = 6;
    localparam int LEN_W  = 9;
    localparam int LINE_W = 20;
    localparam int ERR_W  = 5;

    localparam logic [LINE_W-1:0] LINE_MAX = 20'hFFFFF;

    localparam logic [KIND_W-1:0] TK_END         = 6'd0;
    localparam logic [KIND_W-1:0] TK_DOT         = 6'd2;
    localparam logic [KIND_W-1:0] TK_SLASHASSIGN = 6'd34;
    localparam logic [KIND_W-1:0] TK_SLASH       = 6'd35;
    localparam logic [KIND_W-1:0] TK_CHAR        = 6'd36;
    localparam logic [KIND_W-1:0] TK_INT         = 6'd37;
    localparam logic [KIND_W-1:0] TK_REAL        = 6'd38;
    localparam logic [KIND_W-1:0] TK_STR         = 6'd39;
    localparam logic [KIND_W-1:0] TK_IDENT       = 6'd40;
    localparam logic [KIND_W-1:0] TK_NONE        = 6'd0;
    localparam logic [KIND_W-1:0] DIAG_KIND      = 6'd55;

    localparam logic [ERR_W-1:0] E_NONE      = 5'd0;
    localparam logic [ERR_W-1:0] E_COMMENT   = 5'd1;
    localparam logic [ERR_W-1:0] E_REAL      = 5'd2;
    localparam logic [ERR_W-1:0] E_INT       = 5'd3;
    localparam logic [ERR_W-1:0] E_HEX       = 5'd4;
    localparam logic [ERR_W-1:0] E_OCT       = 5'd5;
    localparam logic [ERR_W-1:0] E_STR_END   = 5'd6;
    localparam logic [ERR_W-1:0] E_STR_ESC   = 5'd7;
    localparam logic [ERR_W-1:0] E_STR_BYTE  = 5'd8;
    localparam logic [ERR_W-1:0] E_CH_CLOSE  = 5'd9;
    localparam logic [ERR_W-1:0] E_CH_ESC    = 5'd10;
    localparam logic [ERR_W-1:0] E_CH_EMPTY  = 5'd11;
    localparam logic [ERR_W-1:0] E_CH_BYTE   = 5'd12;
    localparam logic [ERR_W-1:0] E_HEX_EMPTY = 5'd13;
    localparam logic [ERR_W-1:0] E_BAD_BYTE  = 5'd14;
    localparam logic [ERR_W-1:0] E_LEX_TRUNC = 5'd15;
    localparam logic [ERR_W-1:0] E_STR_TRUNC = 5'd16;

    typedef enum logic [22:0] {
        M_IDLE       = 23'h000001,
        M_OPPEND     = 23'h000002,
        M_DOTPEND    = 23'h000004,
        M_SLASHPEND  = 23'h000008,
        M_BLOCK      = 23'h000010,
        M_BLOCKSTAR  = 23'h000020,
        M_LINE       = 23'h000040,
        M_IDENT      = 23'h000080,
        M_ZERO       = 23'h000100,
        M_HEXSTART   = 23'h000200,
        M_HEX        = 23'h000400,
        M_OCT        = 23'h000800,
        M_INT        = 23'h001000,
        M_FRAC       = 23'h002000,
        M_EXPSTART   = 23'h004000,
        M_EXPDIG     = 23'h008000,
        M_STRING     = 23'h010000,
        M_STRESC     = 23'h020000,
        M_CH1        = 23'h040000,
        M_CH2        = 23'h080000,
        M_CHESC      = 23'h100000,
        M_CHESCCLOSE = 23'h200000,
        M_CHSKIP     = 23'h400000
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic [7:0]        cval;
        logic [ERR_W-1:0]  err;
    } result_t;

    typedef struct packed {
        result_t r;
        logic    last;
    } beat_t;

    typedef struct packed {
        mode_t             mode;
        logic [KIND_W-1:0] pend;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] tline;
        logic [7:0][7:0]   kw;
        logic [7:0]        lit0;
        logic [7:0]        lit1;
    } lex_state_t;

    localparam logic [63:0] KW_TXT [17] = '{
        64'("void"), 64'("char"), 64'("int"), 64'("float"), 64'("const"),
        64'("struct"), 64'("for"), 64'("while"), 64'("do"), 64'("if"),
        64'("else"), 64'("break"), 64'("continue"), 64'("return"),
        64'("switch"), 64'("case"), 64'("default")
    };
    localparam logic [3:0] KW_LEN [17] = '{
        4'd4, 4'd4, 4'd3, 4'd5, 4'd5, 4'd6, 4'd3, 4'd5, 4'd2, 4'd2,
        4'd4, 4'd5, 4'd8, 4'd6, 4'd6, 4'd4, 4'd7
    };
    localparam logic [KIND_W-1:0] KW_KIND [17] = '{
        6'd41, 6'd41, 6'd41, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46,
        6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54
    };

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_digit(c) || is_alpha(c) || (c == "_");
    endfunction

    function automatic logic is_xdigit(logic [7:0] c);
        return is_digit(c) || (c inside {["a":"f"], ["A":"F"]});
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_print(logic [7:0] c);
        return c inside {[8'h20:8'h7E]};
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            ",":     k = 6'd1;
            ";":     k = 6'd3;
            "(":     k = 6'd4;
            ")":     k = 6'd5;
            "[":     k = 6'd6;
            "]":     k = 6'd7;
            "{":     k = 6'd8;
            "}":     k = 6'd9;
            "%":     k = 6'd24;
            ":":     k = 6'd25;
            "?":     k = 6'd26;
            "~":     k = 6'd27;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pend_kind(logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            ">":     k = 6'd11;
            "<":     k = 6'd13;
            "=":     k = 6'd15;
            "+":     k = 6'd18;
            "-":     k = 6'd21;
            "*":     k = 6'd23;
            "|":     k = 6'd29;
            "&":     k = 6'd31;
            "!":     k = 6'd33;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(logic [KIND_W-1:0] base, logic [7:0] c);
        logic [KIND_W-1:0] k;
        k = TK_NONE;
        case (base)
            6'd11:   if (c == "=") k = 6'd10;
            6'd13:   if (c == "=") k = 6'd12;
            6'd15:   if (c == "=") k = 6'd14;
            6'd18:   if (c == "=") k = 6'd16; else if (c == "+") k = 6'd17;
            6'd21:   if (c == "=") k = 6'd19; else if (c == "-") k = 6'd20;
            6'd23:   if (c == "=") k = 6'd22;
            6'd29:   if (c == "|") k = 6'd28;
            6'd31:   if (c == "&") k = 6'd30;
            6'd33:   if (c == "=") k = 6'd32;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic esc_ok(logic [7:0] c, logic str);
        return (c inside {"a", "b", "n", "r", "t", 8'h5C}) ||
               (str ? (c == 8'h22) : (c == 8'h27));
    endfunction

    function automatic logic [7:0] esc_value(logic [7:0] c);
        logic [7:0] v;
        case (c)
            "a":     v = 8'd7;
            "b":     v = 8'd8;
            "n":     v = 8'd10;
            "r":     v = 8'd13;
            "t":     v = 8'd9;
            default: v = c;
        endcase
        return v;
    endfunction

    // Keyword lookup over the first eight kept bytes of an identifier.
    function automatic logic [KIND_W-1:0] kw_kind(logic [7:0][7:0] b, logic [LEN_W-1:0] n);
        logic [KIND_W-1:0] k;
        logic              hit;
        int                l;
        k = TK_IDENT;
        for (int i = 16; i >= 0; i--)
        begin
            l   = int'(KW_LEN[i]);
            hit = (n == LEN_W'(KW_LEN[i]));
            for (int j = 0; j < 8; j++)
            begin
                if (j < l && b[j] != KW_TXT[i][8*((l-1-j) & 7) +: 8])
                    hit = 1'b0;
            end
            if (hit)
                k = KW_KIND[i];
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/clex_fifo.sv]
// Result queue of the C subset lexer: takes up to three beats per cycle, gives one.
// Depends on clex_pkg for the beat type.
`default_nettype none

module clex_fifo #(
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [1:0]               push_count,
    input  wire clex_pkg::beat_t [2:0]    push_data,
    input  wire logic                     pop,
    output clex_pkg::beat_t               head,
    output logic                          head_valid,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import clex_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    beat_t           mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_next = wr_ptr_reg + PW'(push_count);
    assign rd_ptr_next = rd_ptr_reg + PW'(do_pop);
    assign count_next  = count_reg + CW'(push_count) - CW'(do_pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(push_count))
                mem[wr_ptr_reg + PW'(i)] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

`default_nettype wire

[rtl/clex_step.sv]
// Scanner state and the per-byte next-state and result logic of the C subset lexer.
// Depends on clex_pkg for state, result types and character classes.
`default_nettype none

module clex_step #(
    parameter int MAX_LEXEME = 64,
    parameter int MAX_STRING = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_valid,
    input  wire logic [7:0]           step_ch,
    output logic [1:0]                res_count,
    output clex_pkg::beat_t [2:0]     res
);
    import clex_pkg::*;

    localparam logic [LEN_W-1:0] LIM_LEX = LEN_W'(MAX_LEXEME);
    localparam logic [LEN_W-1:0] LIM_STR = LEN_W'(MAX_STRING);

    typedef struct packed {
        lex_state_t       s;
        logic             ok;
        logic [1:0]       n;
        result_t [1:0]    r;
    } feed_t;

    lex_state_t state_reg;
    lex_state_t state_next;
    feed_t      f1;
    feed_t      f2;

    function automatic result_t mk_diag(logic [ERR_W-1:0] err, logic [LINE_W-1:0] line);
        result_t r;
        r.kind = DIAG_KIND;
        r.len  = '0;
        r.line = line;
        r.cval = '0;
        r.err  = err;
        return r;
    endfunction

    function automatic result_t mk_tok(lex_state_t s, logic [KIND_W-1:0] kind,
                                       logic [7:0] cval);
        result_t          r;
        logic [LEN_W-1:0] lim;
        lim    = (kind == TK_STR) ? LIM_STR : LIM_LEX;
        r.kind = kind;
        r.len  = (s.len < lim) ? s.len : lim;
        r.line = s.tline;
        r.cval = cval;
        r.err  = E_NONE;
        return r;
    endfunction

    function automatic feed_t push(feed_t f, result_t r);
        feed_t g;
        g = f;
        g.r[f.n[0]] = r;
        g.n = f.n + 2'd1;
        return g;
    endfunction

    function automatic feed_t app(feed_t f, logic [7:0] c, logic str);
        feed_t            g;
        logic [LEN_W-1:0] lim;
        g   = f;
        lim = str ? LIM_STR : LIM_LEX;
        if (g.s.len < lim)
        begin
            if (g.s.len < LEN_W'(8))
                g.s.kw[g.s.len[2:0]] = c;
            g.s.len = g.s.len + LEN_W'(1);
        end
        else if (g.s.len == lim)
        begin
            g = push(g, mk_diag(str ? E_STR_TRUNC : E_LEX_TRUNC, g.s.line));
            g.s.len = lim + LEN_W'(1);
        end
        return g;
    endfunction

    function automatic feed_t end_num(feed_t f, logic [7:0] c, logic [KIND_W-1:0] kind,
                                      logic [ERR_W-1:0] err);
        feed_t g;
        g = f;
        if (is_word(c))
            g = push(g, mk_diag(err, g.s.line));
        g = push(g, mk_tok(g.s, kind, 8'd0));
        g.s.mode = M_IDLE;
        g.ok = 1'b0;
        return g;
    endfunction

    function automatic feed_t feed(lex_state_t si, logic [7:0] c);
        feed_t             f;
        logic [KIND_W-1:0] k;
        logic [LEN_W-1:0]  n;
        f.s  = si;
        f.ok = 1'b1;
        f.n  = 2'd0;
        f.r  = '0;
        k    = pair_kind(si.pend, c);
        n    = (si.len < LIM_LEX) ? si.len : LIM_LEX;
        case (si.mode)
            M_OPPEND:
            begin
                f.s.mode = M_IDLE;
                if (k != TK_NONE)
                begin
                    f = app(f, c, 1'b0);
                    f = push(f, mk_tok(f.s, k, 8'd0));
                end
                else
                begin
                    f = push(f, mk_tok(f.s, si.pend, 8'd0));
                    f.ok = 1'b0;
                end
            end
            M_DOTPEND:
            begin
                if (is_digit(c))
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_FRAC;
                end
                else
                begin
                    f = push(f, mk_tok(f.s, TK_DOT, 8'd0));
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
            end
            M_SLASHPEND:
            begin
                if (c == "*")
                    f.s.mode = M_BLOCK;
                else if (c == "/")
                    f.s.mode = M_LINE;
                else
                begin
                    f.s.mode = M_IDLE;
                    if (c == "=")
                    begin
                        f = app(f, c, 1'b0);
                        f = push(f, mk_tok(f.s, TK_SLASHASSIGN, 8'd0));
                    end
                    else
                    begin
                        f = push(f, mk_tok(f.s, TK_SLASH, 8'd0));
                        f.ok = 1'b0;
                    end
                end
            end
            M_BLOCK, M_BLOCKSTAR:
            begin
                if (c == 8'd0)
                begin
                    f = push(f, mk_diag(E_COMMENT, si.tline));
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
                else if (si.mode == M_BLOCKSTAR && c == "/")
                    f.s.mode = M_IDLE;
                else
                    f.s.mode = (c == "*") ? M_BLOCKSTAR : M_BLOCK;
            end
            M_LINE:
            begin
                if (c == 8'd0)
                begin
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
                else if (c == 8'd10)
                    f.s.mode = M_IDLE;
            end
            M_IDENT:
            begin
                if (is_word(c))
                    f = app(f, c, 1'b0);
                else
                begin
                    f = push(f, mk_tok(f.s, kw_kind(si.kw, n), 8'd0));
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
            end
            M_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_HEXSTART;
                end
                else if (c inside {["0":"7"]})
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_OCT;
                end
                else if (c == "8" || c == "9")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_INT;
                end
                else if (c == ".")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_FRAC;
                end
                else if (c == "e" || c == "E")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_EXPSTART;
                end
                else
                    f = end_num(f, c, TK_INT, E_INT);
            end
            M_HEXSTART:
            begin
                if (is_xdigit(c))
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_HEX;
                end
                else
                begin
                    f = push(f, mk_diag(E_HEX_EMPTY, si.line));
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
            end
            M_HEX:
            begin
                if (is_xdigit(c))
                    f = app(f, c, 1'b0);
                else
                    f = end_num(f, c, TK_INT, E_HEX);
            end
            M_OCT:
            begin
                if (c inside {["0":"7"]})
                    f = app(f, c, 1'b0);
                else
                    f = end_num(f, c, TK_INT, E_OCT);
            end
            M_INT:
            begin
                if (is_digit(c))
                    f = app(f, c, 1'b0);
                else if (c == ".")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_FRAC;
                end
                else if (c == "e" || c == "E")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_EXPSTART;
                end
                else
                    f = end_num(f, c, TK_INT, E_INT);
            end
            M_FRAC:
            begin
                if (is_digit(c))
                    f = app(f, c, 1'b0);
                else if (c == "e" || c == "E")
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_EXPSTART;
                end
                else
                    f = end_num(f, c, TK_REAL, E_REAL);
            end
            M_EXPSTART:
            begin
                if (c == "+" || c == "-" || is_digit(c))
                begin
                    f = app(f, c, 1'b0);
                    f.s.mode = M_EXPDIG;
                end
                else
                    f = end_num(f, c, TK_REAL, E_REAL);
            end
            M_EXPDIG:
            begin
                if (is_digit(c))
                    f = app(f, c, 1'b0);
                else
                    f = end_num(f, c, TK_REAL, E_REAL);
            end
            M_STRING:
            begin
                if (c == 8'd0)
                begin
                    f = push(f, mk_diag(E_STR_END, si.line));
                    f = push(f, mk_tok(f.s, TK_STR, 8'd0));
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
                else if (c == 8'h5C)
                begin
                    f = app(f, c, 1'b1);
                    f.s.mode = M_STRESC;
                end
                else if (c == 8'h22)
                begin
                    f = app(f, c, 1'b1);
                    f = push(f, mk_tok(f.s, TK_STR, 8'd0));
                    f.s.mode = M_IDLE;
                end
                else if (!is_print(c) && !is_space(c))
                    f = push(f, mk_diag(E_STR_BYTE, si.line));
                else
                    f = app(f, c, 1'b1);
            end
            M_STRESC:
            begin
                if (esc_ok(c, 1'b1))
                begin
                    f = app(f, c, 1'b1);
                    f.s.mode = M_STRING;
                end
                else
                begin
                    f = push(f, mk_diag(E_STR_ESC, si.line));
                    f = push(f, mk_tok(f.s, TK_STR, 8'd0));
                    f.s.mode = M_IDLE;
                    f.ok = 1'b0;
                end
            end
            M_CH1:
            begin
                if (c == 8'h5C)
                    f.s.mode = M_CHESC;
                else
                begin
                    f.s.mode = M_IDLE;
                    if (c == 8'h27)
                        f = push(f, mk_diag(E_CH_EMPTY, si.tline));
                    else if (!is_print(c))
                    begin
                        f = push(f, mk_diag(E_CH_BYTE, si.tline));
                        if (c == 8'd0)
                            f.ok = 1'b0;
                        else
                            f.s.mode = M_CHSKIP;
                    end
                    else
                    begin
                        f.s.lit0 = c;
                        f.s.mode = M_CH2;
                    end
                end
            end
            M_CH2:
            begin
                f.s.mode = M_IDLE;
                if (c == 8'h27)
                begin
                    f.s.len = LEN_W'(3);
                    f = push(f, mk_tok(f.s, TK_CHAR, si.lit0));
                end
                else
                begin
                    f = push(f, mk_diag(E_CH_CLOSE, si.tline));
                    f.ok = (c != 8'd0);
                end
            end
            M_CHESC:
            begin
                if (esc_ok(c, 1'b0))
                begin
                    f.s.lit1 = c;
                    f.s.mode = M_CHESCCLOSE;
                end
                else
                begin
                    f.s.mode = M_IDLE;
                    f = push(f, mk_diag(E_CH_ESC, si.tline));
                    f.ok = (c != 8'd0);
                end
            end
            M_CHESCCLOSE:
            begin
                f.s.mode = M_IDLE;
                if (c == 8'h27)
                begin
                    f.s.len = LEN_W'(4);
                    f = push(f, mk_tok(f.s, TK_CHAR, esc_value(si.lit1)));
                end
                else
                begin
                    f = push(f, mk_diag(E_CH_CLOSE, si.tline));
                    f.ok = 1'b0;
                end
            end
            M_CHSKIP:
            begin
                f.s.mode = M_IDLE;
                f.ok = (c != 8'd0);
            end
            default:
            begin
                f.s.mode = M_IDLE;
                if (c == 8'd0)
                begin
                    f = push(f, mk_diag(E_NONE, si.line));
                    f.r[0].kind = TK_END;
                    f.s.line  = LINE_W'(1);
                    f.s.tline = LINE_W'(1);
                end
                else if (!is_space(c))
                begin
                    f.s.tline = si.line;
                    f.s.len   = '0;
                    if (single_kind(c) != TK_NONE)
                    begin
                        f = app(f, c, 1'b0);
                        f = push(f, mk_tok(f.s, single_kind(c), 8'd0));
                    end
                    else if (pend_kind(c) != TK_NONE)
                    begin
                        f = app(f, c, 1'b0);
                        f.s.pend = pend_kind(c);
                        f.s.mode = M_OPPEND;
                    end
                    else if (c == ".")
                    begin
                        f = app(f, c, 1'b0);
                        f.s.mode = M_DOTPEND;
                    end
                    else if (c == "/")
                    begin
                        f = app(f, c, 1'b0);
                        f.s.mode = M_SLASHPEND;
                    end
                    else if (c == 8'h22)
                    begin
                        f = app(f, c, 1'b1);
                        f.s.mode = M_STRING;
                    end
                    else if (c == 8'h27)
                        f.s.mode = M_CH1;
                    else if (c == "0")
                    begin
                        f = app(f, c, 1'b0);
                        f.s.mode = M_ZERO;
                    end
                    else if (is_digit(c))
                    begin
                        f = app(f, c, 1'b0);
                        f.s.mode = M_INT;
                    end
                    else if (is_alpha(c) || c == "_")
                    begin
                        f = app(f, c, 1'b0);
                        f.s.mode = M_IDENT;
                    end
                    else
                        f = push(f, mk_diag(E_BAD_BYTE, si.line));
                end
            end
        endcase
        return f;
    endfunction

    always_comb
    begin
        logic [1:0] cnt;
        f1 = feed(state_reg, step_ch);
        if (!f1.ok)
            f2 = feed(f1.s, step_ch);
        else
        begin
            f2    = f1;
            f2.n  = 2'd0;
        end
        state_next = f2.s;
        if (step_ch == 8'd10 && state_next.line < LINE_MAX)
            state_next.line = state_next.line + LINE_W'(1);

        res = '0;
        cnt = 2'd0;
        for (int i = 0; i < 2; i++)
        begin
            if (i < int'(f1.n) && cnt != 2'd3)
            begin
                res[cnt].r = f1.r[i];
                cnt = cnt + 2'd1;
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (i < int'(f2.n) && cnt != 2'd3)
            begin
                res[cnt].r = f2.r[i];
                cnt = cnt + 2'd1;
            end
        end
        if (cnt != 2'd0)
            res[cnt - 2'd1].last = 1'b1;
        res_count = step_valid ? cnt : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= M_IDLE;
            state_reg.pend  <= '0;
            state_reg.len   <= '0;
            state_reg.line  <= LINE_W'(1);
            state_reg.tline <= LINE_W'(1);
            state_reg.kw    <= '0;
            state_reg.lit0  <= '0;
            state_reg.lit1  <= '0;
        end
        else if (step_valid)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/c_subset_lexer.sv]
// Top level of the C subset lexer: input register, scanner step and result queue.
// Depends on clex_pkg, clex_step and clex_fifo.
//
//   Channel   Handshake             Beat contents
//   input     in_valid / in_ready   ch
//   output    out_valid / out_ready token_kind, token_length, start_line, char_value,
//                                   error_code, last_result
//
// A byte is registered on acceptance and lexed in the next cycle; its result beats go
// into the queue. One byte is taken per cycle while in_ready is high; a byte yields
// zero to three result beats that drain one per cycle while out_ready is high from an
// eight-entry queue, and in_ready falls when that queue holds more than two beats.
// Reset clears the scanner to idle at line one.
`default_nettype none

module c_subset_lexer #(
    parameter int MAX_LEXEME = 64,
    parameter int MAX_STRING = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       token_kind,
    output logic [8:0]       token_length,
    output logic [19:0]      start_line,
    output logic [7:0]       char_value,
    output logic [4:0]       error_code,
    output logic             last_result
);
    import clex_pkg::*;

    localparam int DEPTH = 8;
    localparam int CW    = $clog2(DEPTH+1);

    logic             in_valid_reg;
    logic [7:0]       ch_reg;
    logic [1:0]       res_count;
    beat_t [2:0]      res;
    beat_t            head;
    logic             head_valid;
    logic [CW-1:0]    fifo_count;

    assign in_ready = (fifo_count <= CW'(DEPTH - 6));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid && in_ready;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ch_reg <= ch;
    end

    clex_step #(
        .MAX_LEXEME (MAX_LEXEME),
        .MAX_STRING (MAX_STRING)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (in_valid_reg),
        .step_ch    (ch_reg),
        .res_count  (res_count),
        .res        (res)
    );

    clex_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push_data  (res),
        .pop        (out_ready),
        .head       (head),
        .head_valid (head_valid),
        .count      (fifo_count)
    );

    assign out_valid    = head_valid;
    assign token_kind   = head.r.kind;
    assign token_length = head.r.len;
    assign start_line   = head.r.line;
    assign char_value   = head.r.cval;
    assign error_code   = head.r.err;
    assign last_result  = head.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (fifo_count <= CW'(DEPTH - 3)))
        else $error("result queue could overflow");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (start_line != '0))
        else $error("result beat carries line zero");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_count != 2'd0) |-> res[res_count - 2'd1].last)
        else $error("final beat of a byte not marked last");

endmodule

`default_nettype wire

[tb/c_subset_lexer_tb.sv]
// Self-checking testbench for c_subset_lexer: random byte streams of C-like source.
// A built-in token predictor produces the expected beats, which are checked in order.
// Depends on clex_pkg and the c_subset_lexer RTL.
`default_nettype none

module c_subset_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clex_pkg::*;

    localparam int LEX_LIM = 64;
    localparam int STR_LIM = 256;
    localparam int WATCHDOG = 4000;
    localparam int QUIET_TAIL = 60;

    typedef struct packed {
        logic [5:0]  kind;
        logic [8:0]  len;
        logic [19:0] line;
        logic [7:0]  cval;
        logic [4:0]  err;
        logic        last;
    } token_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [8:0]  token_length;
    logic [19:0] start_line;
    logic [7:0]  char_value;
    logic [4:0]  error_code;
    logic        last_result;

    c_subset_lexer u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .token_length(token_length), .start_line(start_line),
        .char_value(char_value), .error_code(error_code), .last_result(last_result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Predictor state.
    mode_t       scan;
    logic [5:0]  op_kind;
    logic [8:0]  lex_len;
    logic [19:0] cur_line;
    logic [19:0] tok_line;
    logic [7:0]  kw_bytes [8];
    logic [7:0]  lit_plain;
    logic [7:0]  lit_esc;

    token_beat_t step_beats [3];
    int          step_cnt;
    token_beat_t expected_tokens [$];
    logic [7:0]  source_bytes [$];

    string       kw_names [17] = '{"void", "char", "int", "float", "const", "struct", "for",
                                   "while", "do", "if", "else", "break", "continue",
                                   "return", "switch", "case", "default"};
    logic [5:0]  kw_kinds [17] = '{6'd41, 6'd41, 6'd41, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45,
                                   6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53,
                                   6'd54};

    int  errors;
    int  sent_cnt;
    int  pause_at;
    int  in_gap;
    int  out_gap;
    int  stall_cnt;
    bit  quiet;

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit wrd(logic [7:0] c);
        return dig(c) || alp(c) || c == "_";
    endfunction

    function automatic bit hexd(logic [7:0] c);
        return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit spc(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit prn(logic [7:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic bit esc_good(logic [7:0] c, bit str);
        return c == "a" || c == "b" || c == "n" || c == "r" || c == "t" || c == 8'h5C ||
               (str ? c == 8'h22 : c == 8'h27);
    endfunction

    function automatic logic [5:0] punct1(logic [7:0] c);
        case (c)
            ",": return 6'd1;
            ";": return 6'd3;
            "(": return 6'd4;
            ")": return 6'd5;
            "[": return 6'd6;
            "]": return 6'd7;
            "{": return 6'd8;
            "}": return 6'd9;
            "%": return 6'd24;
            ":": return 6'd25;
            "?": return 6'd26;
            "~": return 6'd27;
            default: return TK_NONE;
        endcase
    endfunction

    function automatic logic [5:0] punct_lead(logic [7:0] c);
        case (c)
            ">": return 6'd11;
            "<": return 6'd13;
            "=": return 6'd15;
            "+": return 6'd18;
            "-": return 6'd21;
            "*": return 6'd23;
            "|": return 6'd29;
            "&": return 6'd31;
            "!": return 6'd33;
            default: return TK_NONE;
        endcase
    endfunction

    function automatic logic [5:0] punct_pair(logic [5:0] b, logic [7:0] c);
        case (b)
            6'd11: return c == "=" ? 6'd10 : TK_NONE;
            6'd13: return c == "=" ? 6'd12 : TK_NONE;
            6'd15: return c == "=" ? 6'd14 : TK_NONE;
            6'd18: return c == "=" ? 6'd16 : (c == "+" ? 6'd17 : TK_NONE);
            6'd21: return c == "=" ? 6'd19 : (c == "-" ? 6'd20 : TK_NONE);
            6'd23: return c == "=" ? 6'd22 : TK_NONE;
            6'd29: return c == "|" ? 6'd28 : TK_NONE;
            6'd31: return c == "&" ? 6'd30 : TK_NONE;
            6'd33: return c == "=" ? 6'd32 : TK_NONE;
            default: return TK_NONE;
        endcase
    endfunction

    function automatic logic [7:0] esc_byte(logic [7:0] c);
        case (c)
            "a": return 8'd7;
            "b": return 8'd8;
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            default: return c;
        endcase
    endfunction

    function automatic void put_beat(logic [5:0] k, int l, logic [19:0] ln,
                                     logic [7:0] cv, logic [4:0] e);
        if (step_cnt < 3)
        begin
            step_beats[step_cnt] = '{k, 9'(l), ln, cv, e, 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void diag(logic [4:0] e, logic [19:0] ln);
        put_beat(DIAG_KIND, 0, ln, 8'd0, e);
    endfunction

    function automatic void keep(logic [7:0] c, bit str);
        int lim;
        lim = str ? STR_LIM : LEX_LIM;
        if (lex_len < lim)
        begin
            if (lex_len < 8)
                kw_bytes[lex_len] = c;
            lex_len++;
        end
        else if (lex_len == lim)
        begin
            diag(str ? E_STR_TRUNC : E_LEX_TRUNC, cur_line);
            lex_len = 9'(lim + 1);
        end
    endfunction

    function automatic void token_out(logic [5:0] k, logic [7:0] cv);
        int lim;
        lim = (k == TK_STR) ? STR_LIM : LEX_LIM;
        put_beat(k, (lex_len < lim) ? int'(lex_len) : lim, tok_line, cv, E_NONE);
    endfunction

    function automatic logic [5:0] word_kind();
        int  n;
        bit  hit;
        n = (lex_len < LEX_LIM) ? int'(lex_len) : LEX_LIM;
        for (int i = 0; i < 17; i++)
        begin
            if (kw_names[i].len() == n)
            begin
                hit = 1'b1;
                for (int j = 0; j < n; j++)
                    if (kw_bytes[j] != kw_names[i][j])
                        hit = 1'b0;
                if (hit)
                    return kw_kinds[i];
            end
        end
        return TK_IDENT;
    endfunction

    function automatic bit close_number(logic [7:0] c, logic [5:0] k, logic [4:0] e);
        if (wrd(c))
            diag(e, cur_line);
        token_out(k, 8'd0);
        scan = M_IDLE;
        return 1'b0;
    endfunction

    function automatic bit start_token(logic [7:0] c);
        logic [5:0] k;
        if (c == 8'd0)
        begin
            put_beat(TK_END, 0, cur_line, 8'd0, E_NONE);
            cur_line = 20'd1;
            tok_line = 20'd1;
            return 1'b1;
        end
        if (spc(c))
            return 1'b1;
        tok_line = cur_line;
        lex_len = 9'd0;
        k = punct1(c);
        if (k != TK_NONE)
        begin
            keep(c, 1'b0);
            token_out(k, 8'd0);
            return 1'b1;
        end
        k = punct_lead(c);
        if (k != TK_NONE)
        begin
            keep(c, 1'b0);
            op_kind = k;
            scan = M_OPPEND;
        end
        else if (c == ".")
        begin
            keep(c, 1'b0);
            scan = M_DOTPEND;
        end
        else if (c == "/")
        begin
            keep(c, 1'b0);
            scan = M_SLASHPEND;
        end
        else if (c == 8'h22)
        begin
            keep(c, 1'b1);
            scan = M_STRING;
        end
        else if (c == 8'h27)
            scan = M_CH1;
        else if (c == "0")
        begin
            keep(c, 1'b0);
            scan = M_ZERO;
        end
        else if (dig(c))
        begin
            keep(c, 1'b0);
            scan = M_INT;
        end
        else if (wrd(c))
        begin
            keep(c, 1'b0);
            scan = M_IDENT;
        end
        else
            diag(E_BAD_BYTE, cur_line);
        return 1'b1;
    endfunction

    // Returns 0 when the byte must be scanned again from the idle state.
    function automatic bit scan_byte(logic [7:0] c);
        logic [5:0] k;
        case (scan)
            M_OPPEND:
            begin
                k = punct_pair(op_kind, c);
                scan = M_IDLE;
                if (k != TK_NONE)
                begin
                    keep(c, 1'b0);
                    token_out(k, 8'd0);
                    return 1'b1;
                end
                token_out(op_kind, 8'd0);
                return 1'b0;
            end
            M_DOTPEND:
            begin
                if (dig(c))
                begin
                    keep(c, 1'b0);
                    scan = M_FRAC;
                    return 1'b1;
                end
                token_out(TK_DOT, 8'd0);
                scan = M_IDLE;
                return 1'b0;
            end
            M_SLASHPEND:
            begin
                if (c == "*")
                begin
                    scan = M_BLOCK;
                    return 1'b1;
                end
                if (c == "/")
                begin
                    scan = M_LINE;
                    return 1'b1;
                end
                scan = M_IDLE;
                if (c == "=")
                begin
                    keep(c, 1'b0);
                    token_out(TK_SLASHASSIGN, 8'd0);
                    return 1'b1;
                end
                token_out(TK_SLASH, 8'd0);
                return 1'b0;
            end
            M_BLOCK, M_BLOCKSTAR:
            begin
                if (c == 8'd0)
                begin
                    diag(E_COMMENT, tok_line);
                    scan = M_IDLE;
                    return 1'b0;
                end
                if (scan == M_BLOCKSTAR && c == "/")
                    scan = M_IDLE;
                else
                    scan = (c == "*") ? M_BLOCKSTAR : M_BLOCK;
                return 1'b1;
            end
            M_LINE:
            begin
                if (c == 8'd0)
                begin
                    scan = M_IDLE;
                    return 1'b0;
                end
                if (c == 8'd10)
                    scan = M_IDLE;
                return 1'b1;
            end
            M_IDENT:
            begin
                if (wrd(c))
                begin
                    keep(c, 1'b0);
                    return 1'b1;
                end
                token_out(word_kind(), 8'd0);
                scan = M_IDLE;
                return 1'b0;
            end
            M_ZERO, M_INT:
            begin
                if (scan == M_ZERO && (c == "x" || c == "X"))
                begin
                    keep(c, 1'b0);
                    scan = M_HEXSTART;
                    return 1'b1;
                end
                if (scan == M_ZERO && c >= "0" && c <= "7")
                begin
                    keep(c, 1'b0);
                    scan = M_OCT;
                    return 1'b1;
                end
                if (dig(c))
                begin
                    keep(c, 1'b0);
                    scan = M_INT;
                    return 1'b1;
                end
                if (c == ".")
                begin
                    keep(c, 1'b0);
                    scan = M_FRAC;
                    return 1'b1;
                end
                if (c == "e" || c == "E")
                begin
                    keep(c, 1'b0);
                    scan = M_EXPSTART;
                    return 1'b1;
                end
                return close_number(c, TK_INT, E_INT);
            end
            M_HEXSTART:
            begin
                if (hexd(c))
                begin
                    keep(c, 1'b0);
                    scan = M_HEX;
                    return 1'b1;
                end
                diag(E_HEX_EMPTY, cur_line);
                scan = M_IDLE;
                return 1'b0;
            end
            M_HEX:
            begin
                if (hexd(c))
                begin
                    keep(c, 1'b0);
                    return 1'b1;
                end
                return close_number(c, TK_INT, E_HEX);
            end
            M_OCT:
            begin
                if (c >= "0" && c <= "7")
                begin
                    keep(c, 1'b0);
                    return 1'b1;
                end
                return close_number(c, TK_INT, E_OCT);
            end
            M_FRAC:
            begin
                if (dig(c))
                begin
                    keep(c, 1'b0);
                    return 1'b1;
                end
                if (c == "e" || c == "E")
                begin
                    keep(c, 1'b0);
                    scan = M_EXPSTART;
                    return 1'b1;
                end
                return close_number(c, TK_REAL, E_REAL);
            end
            M_EXPSTART:
            begin
                if (c == "+" || c == "-" || dig(c))
                begin
                    keep(c, 1'b0);
                    scan = M_EXPDIG;
                    return 1'b1;
                end
                return close_number(c, TK_REAL, E_REAL);
            end
            M_EXPDIG:
            begin
                if (dig(c))
                begin
                    keep(c, 1'b0);
                    return 1'b1;
                end
                return close_number(c, TK_REAL, E_REAL);
            end
            M_STRING:
            begin
                if (c == 8'd0)
                begin
                    diag(E_STR_END, cur_line);
                    token_out(TK_STR, 8'd0);
                    scan = M_IDLE;
                    return 1'b0;
                end
                if (c == 8'h5C)
                begin
                    keep(c, 1'b1);
                    scan = M_STRESC;
                    return 1'b1;
                end
                if (c == 8'h22)
                begin
                    keep(c, 1'b1);
                    token_out(TK_STR, 8'd0);
                    scan = M_IDLE;
                    return 1'b1;
                end
                if (!prn(c) && !spc(c))
                    diag(E_STR_BYTE, cur_line);
                else
                    keep(c, 1'b1);
                return 1'b1;
            end
            M_STRESC:
            begin
                if (esc_good(c, 1'b1))
                begin
                    keep(c, 1'b1);
                    scan = M_STRING;
                    return 1'b1;
                end
                diag(E_STR_ESC, cur_line);
                token_out(TK_STR, 8'd0);
                scan = M_IDLE;
                return 1'b0;
            end
            M_CH1:
            begin
                if (c == 8'h5C)
                begin
                    scan = M_CHESC;
                    return 1'b1;
                end
                scan = M_IDLE;
                if (c == 8'h27)
                begin
                    diag(E_CH_EMPTY, tok_line);
                    return 1'b1;
                end
                if (!prn(c))
                begin
                    diag(E_CH_BYTE, tok_line);
                    if (c == 8'd0)
                        return 1'b0;
                    scan = M_CHSKIP;
                    return 1'b1;
                end
                lit_plain = c;
                scan = M_CH2;
                return 1'b1;
            end
            M_CH2:
            begin
                scan = M_IDLE;
                if (c == 8'h27)
                begin
                    lex_len = 9'd3;
                    token_out(TK_CHAR, lit_plain);
                    return 1'b1;
                end
                diag(E_CH_CLOSE, tok_line);
                return c != 8'd0;
            end
            M_CHESC:
            begin
                if (esc_good(c, 1'b0))
                begin
                    lit_esc = c;
                    scan = M_CHESCCLOSE;
                    return 1'b1;
                end
                scan = M_IDLE;
                diag(E_CH_ESC, tok_line);
                return c != 8'd0;
            end
            M_CHESCCLOSE:
            begin
                scan = M_IDLE;
                if (c == 8'h27)
                begin
                    lex_len = 9'd4;
                    token_out(TK_CHAR, esc_byte(lit_esc));
                    return 1'b1;
                end
                diag(E_CH_CLOSE, tok_line);
                return 1'b0;
            end
            M_CHSKIP:
            begin
                scan = M_IDLE;
                return c != 8'd0;
            end
            default:
            begin
                scan = M_IDLE;
                return start_token(c);
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        step_cnt = 0;
        if (!scan_byte(c))
            void'(scan_byte(c));
        if (c == 8'd10 && cur_line < LINE_MAX)
            cur_line++;
        for (int i = 0; i < step_cnt; i++)
        begin
            step_beats[i].last = (i == step_cnt - 1);
            expected_tokens.push_back(step_beats[i]);
        end
    endfunction

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            source_bytes.push_back(s[i]);
    endtask

    task automatic put_word(int n);
        source_bytes.push_back($urandom_range(0, 3) == 0 ? "_" : 8'($urandom_range(97, 122)));
        for (int i = 1; i < n; i++)
            case ($urandom_range(0, 3))
                0: source_bytes.push_back(8'($urandom_range(48, 57)));
                1: source_bytes.push_back(8'($urandom_range(65, 90)));
                default: source_bytes.push_back(8'($urandom_range(97, 122)));
            endcase
    endtask

    task automatic put_digits(int n, int hi);
        for (int i = 0; i < n; i++)
            source_bytes.push_back(8'($urandom_range(48, hi)));
    endtask

    task automatic put_string_lit();
        string escs;
        escs = "abnrt\\\"";
        source_bytes.push_back(8'h22);
        repeat ($urandom_range(0, 6))
            case ($urandom_range(0, 9))
                0:
                begin
                    source_bytes.push_back(8'h5C);
                    source_bytes.push_back(escs[$urandom_range(0, 6)]);
                end
                1:
                begin
                    source_bytes.push_back(8'h5C);
                    source_bytes.push_back("q");
                end
                2: source_bytes.push_back(8'($urandom_range(128, 255)));
                3: source_bytes.push_back(8'($urandom_range(1, 31)));
                default: source_bytes.push_back(8'($urandom_range(32, 126)));
            endcase
        if ($urandom_range(0, 7) != 0)
            source_bytes.push_back(8'h22);
    endtask

    task automatic put_char_lit();
        string escs;
        escs = "abnrt\\'";
        source_bytes.push_back(8'h27);
        case ($urandom_range(0, 7))
            0:
            begin
                source_bytes.push_back(8'h5C);
                source_bytes.push_back(escs[$urandom_range(0, 6)]);
                source_bytes.push_back(8'h27);
            end
            1: source_bytes.push_back(8'h27);
            2:
            begin
                source_bytes.push_back(8'($urandom_range(128, 255)));
                source_bytes.push_back("k");
            end
            3:
            begin
                source_bytes.push_back("m");
                source_bytes.push_back(";");
            end
            4:
            begin
                source_bytes.push_back(8'h5C);
                source_bytes.push_back("z");
            end
            5:
            begin
                source_bytes.push_back(8'h5C);
                source_bytes.push_back("n");
                source_bytes.push_back("w");
            end
            default:
            begin
                source_bytes.push_back(8'($urandom_range(32, 126)));
                source_bytes.push_back(8'h27);
            end
        endcase
    endtask

    task automatic put_fragment();
        string ops;
        ops = ",;()[]{}%:?~><=+-*|&!/.";
        case ($urandom_range(0, 16))
            0, 1: put_word($urandom_range(1, 9));
            2: put_text(kw_names[$urandom_range(0, 16)]);
            3:
            begin
                source_bytes.push_back(8'($urandom_range(49, 57)));
                put_digits($urandom_range(0, 3), 57);
                if ($urandom_range(0, 1))
                begin
                    source_bytes.push_back(".");
                    put_digits($urandom_range(0, 3), 57);
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    source_bytes.push_back($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1))
                        source_bytes.push_back($urandom_range(0, 1) ? "+" : "-");
                    put_digits($urandom_range(0, 2), 57);
                end
            end
            4:
            begin
                put_text($urandom_range(0, 1) ? "0x" : "0X");
                repeat ($urandom_range(0, 4))
                    source_bytes.push_back(
                        $urandom_range(0, 1) ? 8'($urandom_range(48, 57))
                                             : 8'($urandom_range(65, 70)));
            end
            5:
            begin
                source_bytes.push_back("0");
                put_digits($urandom_range(0, 3), 57);
            end
            6: put_string_lit();
            7: put_char_lit();
            8:
            begin
                put_text("/*");
                repeat ($urandom_range(0, 5))
                    source_bytes.push_back($urandom_range(0, 2) == 0 ? "*" : 8'($urandom_range(1, 255)));
                if ($urandom_range(0, 4) != 0)
                    put_text("*/");
            end
            9:
            begin
                put_text("//");
                put_word($urandom_range(1, 5));
                source_bytes.push_back(8'd10);
            end
            10, 11:
            begin
                source_bytes.push_back(ops[$urandom_range(0, ops.len() - 1)]);
                source_bytes.push_back(ops[$urandom_range(0, ops.len() - 1)]);
            end
            12: source_bytes.push_back($urandom_range(0, 1) ? 8'd10 : 8'($urandom_range(9, 13)));
            13: source_bytes.push_back(8'($urandom_range(1, 255)));
            14: source_bytes.push_back(8'd0);
            15:
            begin
                source_bytes.push_back(".");
                put_digits($urandom_range(0, 2), 57);
            end
            default: put_text("0.e");
        endcase
        if ($urandom_range(0, 1))
            source_bytes.push_back($urandom_range(0, 3) == 0 ? 8'd10 : " ");
    endtask

    initial
    begin
        rst_n = 1'b0;
        scan = M_IDLE;
        op_kind = '0;
        lex_len = '0;
        cur_line = 20'd1;
        tok_line = 20'd1;
        errors = 0;

        put_text("if(x>=.5) 0x1F 'a' \"\\n\"");
        source_bytes.push_back(8'd10);
        source_bytes.push_back(8'hFF);
        source_bytes.push_back(8'd0);
        pause_at = source_bytes.size();

        put_word(70);
        source_bytes.push_back(" ");
        while (source_bytes.size() < 222)
            put_fragment();
        put_text("/* open");
        source_bytes.push_back(8'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (source_bytes.size() == 0 && !in_valid && expected_tokens.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch <= 8'd0;
            in_gap <= 0;
            sent_cnt <= 0;
            quiet <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_byte(ch);
                sent_cnt <= sent_cnt + 1;
            end
            quiet <= source_bytes.size() < QUIET_TAIL;
            if (in_valid && !in_ready)
                in_valid <= 1'b1;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if ((sent_cnt + (in_valid ? 1 : 0)) == pause_at &&
                     (expected_tokens.size() != 0 || in_valid))
                in_valid <= 1'b0;
            else if (source_bytes.size() == 0)
                in_valid <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_gap <= $urandom_range(1, 6) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                ch <= source_bytes.pop_front();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        token_beat_t got;
        token_beat_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
            stall_cnt <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{token_kind, token_length, start_line, char_value, error_code,
                        last_result};
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual %p", $realtime, got);
                    errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.kind != want.kind)
                        $display("%0t: token_kind expected %0d actual %0d",
                                 $realtime, want.kind, got.kind);
                    if (got.len != want.len)
                        $display("%0t: token_length expected %0d actual %0d",
                                 $realtime, want.len, got.len);
                    if (got.line != want.line)
                        $display("%0t: start_line expected %0d actual %0d",
                                 $realtime, want.line, got.line);
                    if (got.cval != want.cval)
                        $display("%0t: char_value expected %0d actual %0d",
                                 $realtime, want.cval, got.cval);
                    if (got.err != want.err)
                        $display("%0t: error_code expected %0d actual %0d",
                                 $realtime, want.err, got.err);
                    if (got.last != want.last)
                        $display("%0t: last_result expected %0d actual %0d",
                                 $realtime, want.last, got.last);
                    if (got != want)
                        errors++;
                end
            end

            if ((out_valid && out_ready) || (in_valid && in_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG)
            begin
                $display("*** FAILED ***");
                $finish;
            end

            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                out_gap <= $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/clex_pkg.sv
rtl/clex_fifo.sv
rtl/clex_step.sv
rtl/c_subset_lexer.sv
tb/c_subset_lexer_tb.sv
